// File: hw/rtl/bbc_pkg.sv
// Shared types and constants for the block buffer cache.
package bbc_pkg;

  // Number of buffer entries, one cell each.
  localparam int NUM_BUFFERS = 32;

  // Width of an internal entry index.
  localparam int IDX_W = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;

  // Width used when comparing an internal index with the 5-bit buffer index field.
  localparam int CMP_W = (IDX_W > 5) ? IDX_W : 5;

  localparam logic [5:0]  REF_MAX   = 6'd63;
  localparam logic [31:0] TICK_NONE = 32'hFFFF_FFFF;

  // Operation codes.
  typedef enum logic [1:0] {
    OP_ACQUIRE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_PIN     = 2'd2,
    OP_UNPIN   = 2'd3
  } op_t;

  // Request that walks the cell chain and collects what it finds.
  typedef struct packed {
    logic             vld;
    op_t              op;
    logic [7:0]       device_id;
    logic [23:0]      block_number;
    logic [4:0]       buffer_index;
    logic [31:0]      now_tick;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             needs_read;
    logic [5:0]       ref_after;
    logic             vic_found;
    logic [IDX_W-1:0] vic_idx;
    logic [31:0]      vic_ts;
  } token_t;

  // Retag command broadcast to all cells after a miss.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [7:0]       device_id;
    logic [23:0]      block_number;
  } retag_t;

endpackage

// File: hw/rtl/bbc_cell.sv
// One buffer entry of the cache with its stage of the request chain.
module bbc_cell
  import bbc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] my_idx,
  input  token_t           tok_in,
  input  retag_t           retag,
  output token_t           tok_out
);

  logic [7:0]  tag_device, tag_device_next;
  logic [23:0] tag_block, tag_block_next;
  logic [5:0]  ref_count, ref_count_next;
  logic        data_valid, data_valid_next;
  logic [31:0] last_release, last_release_next;
  token_t      tok_next;

  logic tag_match;
  logic idx_match;
  logic retag_me;

  assign tag_match = (tag_device == tok_in.device_id) && (tag_block == tok_in.block_number);
  assign idx_match = (CMP_W'(tok_in.buffer_index) == CMP_W'(my_idx));
  assign retag_me  = retag.en && (retag.idx == my_idx);

  // Entry update and token hand-off.
  always_comb begin
    tag_device_next   = tag_device;
    tag_block_next    = tag_block;
    ref_count_next    = ref_count;
    data_valid_next   = data_valid;
    last_release_next = last_release;
    tok_next          = tok_in;

    if (retag_me) begin
      tag_device_next = retag.device_id;
      tag_block_next  = retag.block_number;
      ref_count_next  = 6'd1;
      data_valid_next = 1'b1;
    end

    if (tok_in.vld) begin
      unique case (tok_in.op)
        OP_ACQUIRE: begin
          // The first matching entry along the chain is the lowest index.
          if (tag_match && !tok_in.hit) begin
            if (ref_count != REF_MAX) begin
              ref_count_next = ref_count + 6'd1;
            end
            data_valid_next     = 1'b1;
            tok_next.hit        = 1'b1;
            tok_next.hit_idx    = my_idx;
            tok_next.needs_read = !data_valid;
            tok_next.ref_after  = (ref_count != REF_MAX) ? ref_count + 6'd1 : ref_count;
          end
          // Strictly older free entry replaces the candidate, so ties keep the lower index.
          if ((ref_count == 6'd0) && (last_release < tok_in.vic_ts)) begin
            tok_next.vic_found = 1'b1;
            tok_next.vic_idx   = my_idx;
            tok_next.vic_ts    = last_release;
          end
        end
        OP_RELEASE: begin
          if (idx_match) begin
            if (ref_count != 6'd0) begin
              ref_count_next = ref_count - 6'd1;
              if (ref_count == 6'd1) begin
                last_release_next = tok_in.now_tick;
              end
            end
            tok_next.ref_after = (ref_count != 6'd0) ? ref_count - 6'd1 : ref_count;
          end
        end
        OP_PIN: begin
          if (idx_match) begin
            if (ref_count != REF_MAX) begin
              ref_count_next = ref_count + 6'd1;
            end
            tok_next.ref_after = (ref_count != REF_MAX) ? ref_count + 6'd1 : ref_count;
          end
        end
        OP_UNPIN: begin
          if (idx_match) begin
            if (ref_count != 6'd0) begin
              ref_count_next = ref_count - 6'd1;
            end
            tok_next.ref_after = (ref_count != 6'd0) ? ref_count - 6'd1 : ref_count;
          end
        end
        default: begin
          tok_next = tok_in;
        end
      endcase
    end
  end

  // Entry state and the outgoing token register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_device   <= '0;
      tag_block    <= '0;
      ref_count    <= '0;
      data_valid   <= 1'b0;
      last_release <= '0;
      tok_out.vld  <= 1'b0;
    end else begin
      tag_device   <= tag_device_next;
      tag_block    <= tag_block_next;
      ref_count    <= ref_count_next;
      data_valid   <= data_valid_next;
      last_release <= last_release_next;
      tok_out.vld  <= tok_next.vld;
    end
    // Token payload needs no reset.
    tok_out.op           <= tok_next.op;
    tok_out.device_id    <= tok_next.device_id;
    tok_out.block_number <= tok_next.block_number;
    tok_out.buffer_index <= tok_next.buffer_index;
    tok_out.now_tick     <= tok_next.now_tick;
    tok_out.hit          <= tok_next.hit;
    tok_out.hit_idx      <= tok_next.hit_idx;
    tok_out.needs_read   <= tok_next.needs_read;
    tok_out.ref_after    <= tok_next.ref_after;
    tok_out.vic_found    <= tok_next.vic_found;
    tok_out.vic_idx      <= tok_next.vic_idx;
    tok_out.vic_ts       <= tok_next.vic_ts;
  end

endmodule

// File: hw/rtl/block_buffer_cache_lru_unit.sv
// Top level of the block buffer cache with reference counts and LRU replacement.
//
// Each request beat walks a chain of NUM_BUFFERS cells, one entry per cell and
// one cell per clock, so the tag lookup, the oldest-free-entry search and the
// count updates all happen as the request passes each entry. After the chain
// walk the result is captured, and once the output register is free the retag
// of any miss victim is committed as the output register is loaded. A new
// request is taken only after the last one has finished in this way. A request
// is taken while an earlier result beat still waits; its own completion waits
// until that beat is taken. All entries are cleared by reset at once; no
// clearing pass is needed.
module block_buffer_cache_lru_unit
  import bbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // op[1:0], device_id[9:2], block_number[33:10], buffer_index[38:34],
  // now_tick[70:39], zero[71]
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[0], hit[1], needs_read[2], entry[7:3], ref_after[13:8], zero[15:14]
  output logic [15:0] m_axis_tdata
);

  token_t tok [0:NUM_BUFFERS];
  retag_t retag;

  logic   busy;
  logic   pend_valid;
  token_t pend;
  logic   s_accept;
  logic   finish;

  logic       res_status;
  logic       res_hit;
  logic       res_needs_read;
  logic [4:0] res_entry;
  logic [5:0] res_ref_after;

  logic [CMP_W-1:0] hit_ext;
  logic [CMP_W-1:0] vic_ext;
  logic             idx_in_range;

  assign s_axis_tready = !busy;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign finish        = pend_valid && (!m_axis_tvalid || m_axis_tready);

  // Build the request token from the accepted beat.
  always_comb begin
    tok[0].vld          = s_accept;
    tok[0].op           = op_t'(s_axis_tdata[1:0]);
    tok[0].device_id    = s_axis_tdata[9:2];
    tok[0].block_number = s_axis_tdata[33:10];
    tok[0].buffer_index = s_axis_tdata[38:34];
    tok[0].now_tick     = s_axis_tdata[70:39];
    tok[0].hit          = 1'b0;
    tok[0].hit_idx      = '0;
    tok[0].needs_read   = 1'b0;
    tok[0].ref_after    = '0;
    tok[0].vic_found    = 1'b0;
    tok[0].vic_idx      = '0;
    tok[0].vic_ts       = TICK_NONE;
  end

  // The chain of entry cells.
  for (genvar i = 0; i < NUM_BUFFERS; i++) begin : g_cell
    bbc_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .my_idx  (IDX_W'(i)),
      .tok_in  (tok[i]),
      .retag   (retag),
      .tok_out (tok[i+1])
    );
  end

  // Result formation from the captured token.
  assign hit_ext      = CMP_W'(pend.hit_idx);
  assign vic_ext      = CMP_W'(pend.vic_idx);
  assign idx_in_range = (32'(pend.buffer_index) < 32'(NUM_BUFFERS));

  always_comb begin
    res_status     = 1'b0;
    res_hit        = 1'b0;
    res_needs_read = 1'b0;
    res_entry      = pend.buffer_index;
    res_ref_after  = pend.ref_after;
    retag.en           = 1'b0;
    retag.idx          = pend.vic_idx;
    retag.device_id    = pend.device_id;
    retag.block_number = pend.block_number;
    if (pend.op == OP_ACQUIRE) begin
      priority if (pend.hit) begin
        res_hit        = 1'b1;
        res_needs_read = pend.needs_read;
        res_entry      = hit_ext[4:0];
      end else if (pend.vic_found) begin
        res_needs_read = 1'b1;
        res_entry      = vic_ext[4:0];
        res_ref_after  = 6'd1;
        retag.en       = finish;
      end else begin
        res_status    = 1'b1;
        res_entry     = '0;
        res_ref_after = '0;
      end
    end else if (!idx_in_range) begin
      res_status    = 1'b1;
      res_ref_after = '0;
    end
  end

  // Request tracking, result capture and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      pend_valid    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s_accept) begin
        busy <= 1'b1;
      end
      if (tok[NUM_BUFFERS].vld) begin
        pend_valid <= 1'b1;
      end
      if (finish) begin
        busy          <= 1'b0;
        pend_valid    <= 1'b0;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (tok[NUM_BUFFERS].vld) begin
      pend <= tok[NUM_BUFFERS];
    end
    if (finish) begin
      m_axis_tdata <= {2'b00, res_ref_after, res_entry, res_needs_read, res_hit, res_status};
    end
  end

endmodule
